### sv/wwa_pkg.sv
// ----------------------------------------------------------------------------
// wwa_pkg
// shared widths for the wrapped wavefront arbiter and its cells
// ----------------------------------------------------------------------------
package wwa_pkg;

  // fixed port widths of the block
  localparam int unsigned MATRIX_W  = 64;
  localparam int unsigned DIAG_W    = 3;
  localparam int unsigned MAX_PORTS = 8;

endpackage

### sv/wrapped_wavefront_arbiter.sv
// ----------------------------------------------------------------------------
// wrapped_wavefront_arbiter
// crossbar matcher built as a chain of wrapped-diagonal wavefront stages
// ----------------------------------------------------------------------------
// Takes one NUM_PORTS x NUM_PORTS request matrix per unstalled clock (bit
// i*NUM_PORTS+j means input i wants output j) and returns a grant matrix with
// at most one grant per row and per column, plus the first-priority diagonal.
// The matrix runs through a chain of NUM_PORTS identical registered stages;
// each stage arbitrates one wrapped diagonal and the last stage is the output
// register, so with no stall a new word can enter every cycle while earlier
// words are still in the chain.
// The priority diagonal starts at 0 after reset and steps by one (mod
// NUM_PORTS) for every accepted word. Request bits beyond NUM_PORTS^2 are
// ignored and the matching grant bits are always zero. Stall propagates back
// only through stages that hold a word, so empty slots are squeezed out.
module wrapped_wavefront_arbiter #(
  parameter int unsigned NUM_PORTS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request side
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [wwa_pkg::MATRIX_W-1:0]  request_matrix_i,
  // grant side
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [wwa_pkg::MATRIX_W-1:0]  grant_matrix_o,
  output logic [wwa_pkg::DIAG_W-1:0]    priority_diagonal_o
);
  import wwa_pkg::*;

  localparam int unsigned PTR_W = $clog2(NUM_PORTS);
  localparam int unsigned NN    = NUM_PORTS * NUM_PORTS;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(NUM_PORTS - 1);

  // chain links: index 0 is the input side, index NUM_PORTS the output register
  logic                                valid_c    [NUM_PORTS+1];
  logic                                stall_c    [NUM_PORTS+1];
  logic [NUM_PORTS-1:0][NUM_PORTS-1:0] req_c      [NUM_PORTS+1];
  logic [NUM_PORTS-1:0][NUM_PORTS-1:0] grant_c    [NUM_PORTS+1];
  logic [NUM_PORTS-1:0]                row_busy_c [NUM_PORTS+1];
  logic [NUM_PORTS-1:0]                col_busy_c [NUM_PORTS+1];
  logic [PTR_W-1:0]                    start_c    [NUM_PORTS+1];

  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic             in_accept;

  assign in_accept = in_valid_i && !in_stall_o;

  // priority pointer, advances once per accepted word
  assign ptr_d = (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (in_accept) begin
      ptr_q <= ptr_d;
    end
  end

  // head of the chain: fresh word, nothing granted yet
  assign valid_c[0]    = in_valid_i;
  assign in_stall_o    = stall_c[0];
  assign req_c[0]      = request_matrix_i[NN-1:0];
  assign grant_c[0]    = '0;
  assign row_busy_c[0] = '0;
  assign col_busy_c[0] = '0;
  assign start_c[0]    = ptr_q;

  // one stage per diagonal step of the sweep
  for (genvar s = 0; s < NUM_PORTS; s++) begin : g_stage
    wwa_cell #(
      .NUM_PORTS (NUM_PORTS),
      .STEP      (s)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .valid_i    (valid_c[s]),
      .stall_o    (stall_c[s]),
      .req_i      (req_c[s]),
      .grant_i    (grant_c[s]),
      .row_busy_i (row_busy_c[s]),
      .col_busy_i (col_busy_c[s]),
      .start_i    (start_c[s]),
      .valid_o    (valid_c[s+1]),
      .stall_i    (stall_c[s+1]),
      .req_o      (req_c[s+1]),
      .grant_o    (grant_c[s+1]),
      .row_busy_o (row_busy_c[s+1]),
      .col_busy_o (col_busy_c[s+1]),
      .start_o    (start_c[s+1])
    );
  end

  // tail of the chain is the output register
  assign out_valid_o         = valid_c[NUM_PORTS];
  assign stall_c[NUM_PORTS]  = out_stall_i;
  assign grant_matrix_o      = MATRIX_W'(grant_c[NUM_PORTS]);
  assign priority_diagonal_o = DIAG_W'(start_c[NUM_PORTS]);

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PTR_LAST)
    else $error("priority pointer out of range");

  a_ptr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (ptr_q == (($past(ptr_q) == PTR_LAST) ? '0 : $past(ptr_q) + PTR_W'(1))))
    else $error("priority pointer did not advance");

  a_diag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, priority_diagonal_o} < (DIAG_W+1)'(NUM_PORTS)))
    else $error("priority diagonal out of range");
`endif

endmodule

### sv/wwa_cell.sv
// ----------------------------------------------------------------------------
// wwa_cell
// one wavefront stage: arbitrates one wrapped diagonal and registers the word
// ----------------------------------------------------------------------------
module wwa_cell #(
  parameter int unsigned NUM_PORTS = 8,
  parameter int unsigned STEP      = 0
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // upstream side
  input  logic                                    valid_i,
  output logic                                    stall_o,
  input  logic [NUM_PORTS-1:0][NUM_PORTS-1:0]     req_i,
  input  logic [NUM_PORTS-1:0][NUM_PORTS-1:0]     grant_i,
  input  logic [NUM_PORTS-1:0]                    row_busy_i,
  input  logic [NUM_PORTS-1:0]                    col_busy_i,
  input  logic [$clog2(NUM_PORTS)-1:0]            start_i,
  // downstream side
  output logic                                    valid_o,
  input  logic                                    stall_i,
  output logic [NUM_PORTS-1:0][NUM_PORTS-1:0]     req_o,
  output logic [NUM_PORTS-1:0][NUM_PORTS-1:0]     grant_o,
  output logic [NUM_PORTS-1:0]                    row_busy_o,
  output logic [NUM_PORTS-1:0]                    col_busy_o,
  output logic [$clog2(NUM_PORTS)-1:0]            start_o
);
  import wwa_pkg::*;

  localparam int unsigned PTR_W = $clog2(NUM_PORTS);
  localparam logic [PTR_W:0] NUM_L  = (PTR_W+1)'(NUM_PORTS);
  localparam logic [PTR_W:0] STEP_L = (PTR_W+1)'(STEP);

  logic                                valid_q;
  logic [NUM_PORTS-1:0][NUM_PORTS-1:0] req_q;
  logic [NUM_PORTS-1:0][NUM_PORTS-1:0] grant_q, grant_d;
  logic [NUM_PORTS-1:0]                row_busy_q, row_busy_d;
  logic [NUM_PORTS-1:0]                col_busy_q, col_busy_d;
  logic [PTR_W-1:0]                    start_q;

  logic [PTR_W:0]                      diag_sum;
  logic [PTR_W-1:0]                    diag;
  logic [PTR_W:0]                      row_sum;
  logic [PTR_W-1:0]                    row;
  logic [NUM_PORTS-1:0][NUM_PORTS-1:0] grant_new;
  logic [NUM_PORTS-1:0]                row_new;
  logic [NUM_PORTS-1:0]                col_new;

  // diagonal handled by this stage
  assign diag_sum = {1'b0, start_i} + STEP_L;
  assign diag     = (diag_sum >= NUM_L) ? PTR_W'(diag_sum - NUM_L) : PTR_W'(diag_sum);

  // cells on one diagonal share no row or column, so all columns run in parallel
  always_comb begin
    grant_new = '0;
    row_new   = '0;
    col_new   = '0;
    row_sum   = '0;
    row       = '0;
    for (int j = 0; j < NUM_PORTS; j++) begin
      row_sum = {1'b0, diag} + NUM_L - (PTR_W+1)'(j);
      row     = (row_sum >= NUM_L) ? PTR_W'(row_sum - NUM_L) : PTR_W'(row_sum);
      if (req_i[row][j] && !row_busy_i[row] && !col_busy_i[j]) begin
        grant_new[row][j] = 1'b1;
        row_new[row]      = 1'b1;
        col_new[j]        = 1'b1;
      end
    end
  end

  assign grant_d    = grant_i | grant_new;
  assign row_busy_d = row_busy_i | row_new;
  assign col_busy_d = col_busy_i | col_new;

  // stage holds only when it has a word and downstream is stalled
  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      req_q      <= req_i;
      grant_q    <= grant_d;
      row_busy_q <= row_busy_d;
      col_busy_q <= col_busy_d;
      start_q    <= start_i;
    end
  end

  assign valid_o    = valid_q;
  assign req_o      = req_q;
  assign grant_o    = grant_q;
  assign row_busy_o = row_busy_q;
  assign col_busy_o = col_busy_q;
  assign start_o    = start_q;

`ifndef SYNTHESIS
  a_grant_in_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ((grant_q & ~req_q) == '0))
    else $error("grant without request");

  a_row_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ($countones(row_busy_q) == $countones(grant_q)))
    else $error("busy rows do not match grants");

  a_col_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ($countones(col_busy_q) == $countones(grant_q)))
    else $error("busy columns do not match grants");
`endif

endmodule
